// ===== hdl/kcc_pkg.sv =====
// Package for the KeeLoq cipher core: round function, nonlinear table and
// pipeline constants. No dependencies; imported by every module of the core.
package kcc_pkg;

	// Width of one cipher block
	localparam int BLK_W = 32;
	// Width of the key and of a key bit index
	localparam int KEY_W = 64;
	localparam int KIDX_W = 6;
	// Rounds folded into one pipeline stage
	localparam int ROUNDS_PER_STAGE = 8;
	// Nonlinear feedback function, one bit per 5-bit tap index
	localparam logic [31:0] NLF_TABLE = 32'h3A5C742E;
	// Decrypt walks the key backwards from this offset
	localparam logic [KIDX_W-1:0] DEC_KEY_OFS = 6'd15;

	// Operation carried with each transaction
	typedef enum logic {
		OP_ENCRYPT = 1'b0,
		OP_DECRYPT = 1'b1
	} kcc_op_t;

	// One round in either direction
	function automatic logic [BLK_W-1:0] kcc_round(
		input logic [BLK_W-1:0] x,
		input kcc_op_t          op,
		input logic             kb
	);
		logic [4:0] idx;
		logic       fb;
		logic [BLK_W-1:0] res;
		unique case (op)
			OP_ENCRYPT: begin
				idx = {x[31], x[26], x[20], x[9], x[1]};
				fb  = x[0] ^ x[16] ^ kb ^ NLF_TABLE[idx];
				res = {fb, x[31:1]};
			end
			OP_DECRYPT: begin
				idx = {x[30], x[25], x[19], x[8], x[0]};
				fb  = x[31] ^ x[15] ^ kb ^ NLF_TABLE[idx];
				res = {x[30:0], fb};
			end
			default: begin
				idx = '0;
				fb  = 1'b0;
				res = x;
			end
		endcase
		return res;
	endfunction

endpackage

// ===== hdl/kcc_stage.sv =====
// One pipeline stage of the KeeLoq core: up to ROUNDS_PER_STAGE rounds and
// the stage register. Depends on kcc_pkg.
module kcc_stage import kcc_pkg::*; #(
	parameter int BASE = 0,
	parameter int NUM  = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic [KEY_W-1:0] key,
	input  logic             vld_i,
	input  kcc_op_t          op_i,
	input  logic [BLK_W-1:0] blk_i,
	output logic             vld_o,
	output kcc_op_t          op_o,
	output logic [BLK_W-1:0] blk_o
);

	logic [BLK_W-1:0] blk_nxt;
	logic             vld_sx;
	kcc_op_t          op_sx;
	logic [BLK_W-1:0] blk_sx;

	// Unrolled rounds of this stage, key bit chosen by absolute round number
	always_comb begin
		logic [BLK_W-1:0]  x;
		logic [KIDX_W-1:0] ridx;
		logic [KIDX_W-1:0] kidx;
		x = blk_i;
		for (int j = 0; j < ROUNDS_PER_STAGE; j++) begin
			ridx = KIDX_W'(BASE + j);
			kidx = (op_i == OP_DECRYPT) ? (DEC_KEY_OFS - ridx) : ridx;
			if (j < NUM) begin
				x = kcc_round(x, op_i, key[kidx]);
			end
		end
		blk_nxt = x;
	end

	// Valid bit, reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sx <= 1'b0;
		end else if (adv) begin
			vld_sx <= vld_i;
		end
	end

	// Payload, no reset
	always_ff @(posedge clk) begin
		if (adv) begin
			op_sx  <= op_i;
			blk_sx <= blk_nxt;
		end
	end

	assign vld_o = vld_sx;
	assign op_o  = op_sx;
	assign blk_o = blk_sx;

endmodule

// ===== hdl/keeloq_cipher_core.sv =====
// KeeLoq block cipher core: round pipeline plus output skid buffer.
// Depends on kcc_pkg and kcc_stage.
//
// Usage:
//   Input channel (in_valid / in_stall) carries kind (0 encrypt, 1 decrypt)
//   and a 32-bit block_in. Output channel (out_valid / out_stall) returns
//   block_out, one per input transaction, in order.
//   The 64-bit key is written through cipher_key_we / cipher_key_wdata and
//   must only change while no transaction is in flight.
// Datapath: an accepted transaction passes through every pipeline stage, each
//   doing eight rounds, and then the output register before out_valid.
// Throughput: one transaction per cycle while in_stall is low, set by the stage
//   register after every eight rounds.
// Reset (arst_n low): key clears to zero, pipeline and output are emptied.
// Stall: a result held on a stalled output is kept stable; the pipeline keeps
//   running into a one-entry skid register, and only once that is full does
//   in_stall rise and the whole pipeline hold. It drops again the cycle after
//   the output is taken.
module keeloq_cipher_core import kcc_pkg::*; #(
	parameter int ROUNDS = 528
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cipher_key_we,
	input  logic [KEY_W-1:0] cipher_key_wdata,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             kind,
	input  logic [BLK_W-1:0] block_in,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [BLK_W-1:0] block_out
);

	localparam int NSTG = (ROUNDS + ROUNDS_PER_STAGE - 1) / ROUNDS_PER_STAGE;

	logic [KEY_W-1:0] key_q;
	logic             vld_s [NSTG];
	kcc_op_t          op_s  [NSTG];
	logic [BLK_W-1:0] blk_s [NSTG];

	logic             out_v_q;
	logic [BLK_W-1:0] out_d_q;
	logic             skid_v_q;
	logic [BLK_W-1:0] skid_d_q;
	logic             adv;
	logic             push;
	logic             pop;

	// Key register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cipher_key_we) begin
			key_q <= cipher_key_wdata;
		end
	end

	// Pipeline moves whenever the skid register is free
	assign adv      = !skid_v_q;
	assign in_stall = skid_v_q;
	assign push     = adv && vld_s[NSTG-1];
	assign pop      = out_v_q && !out_stall;

	// Round pipeline
	for (genvar k = 0; k < NSTG; k++) begin : g_stg
		localparam int BASE = k * ROUNDS_PER_STAGE;
		localparam int LEFT = ROUNDS - BASE;
		localparam int NUM  = (LEFT < ROUNDS_PER_STAGE) ? LEFT : ROUNDS_PER_STAGE;
		if (k == 0) begin : g_first
			kcc_stage #(.BASE(BASE), .NUM(NUM)) u_stage (
				.clk   (clk),
				.arst_n(arst_n),
				.adv   (adv),
				.key   (key_q),
				.vld_i (in_valid),
				.op_i  (kcc_op_t'(kind)),
				.blk_i (block_in),
				.vld_o (vld_s[k]),
				.op_o  (op_s[k]),
				.blk_o (blk_s[k])
			);
		end else begin : g_next
			kcc_stage #(.BASE(BASE), .NUM(NUM)) u_stage (
				.clk   (clk),
				.arst_n(arst_n),
				.adv   (adv),
				.key   (key_q),
				.vld_i (vld_s[k-1]),
				.op_i  (op_s[k-1]),
				.blk_i (blk_s[k-1]),
				.vld_o (vld_s[k]),
				.op_o  (op_s[k]),
				.blk_o (blk_s[k])
			);
		end
	end

	// Output register and skid: valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			priority if (skid_v_q && pop) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else if (push) begin
				if (!out_v_q || pop) begin
					out_v_q <= 1'b1;
				end else begin
					skid_v_q <= 1'b1;
				end
			end else if (pop) begin
				out_v_q <= 1'b0;
			end else begin
				out_v_q  <= out_v_q;
				skid_v_q <= skid_v_q;
			end
		end
	end

	// Output register and skid: data
	always_ff @(posedge clk) begin
		priority if (skid_v_q && pop) begin
			out_d_q <= skid_d_q;
		end else if (push) begin
			if (!out_v_q || pop) begin
				out_d_q <= blk_s[NSTG-1];
			end else begin
				skid_d_q <= blk_s[NSTG-1];
			end
		end else begin
			out_d_q  <= out_d_q;
			skid_d_q <= skid_d_q;
		end
	end

	assign out_valid = out_v_q;
	assign block_out = out_d_q;

endmodule

// ===== hdl/kcc_checker.sv =====
// Port-level checker for the KeeLoq cipher core and its bind.
// No package needed; attaches to keeloq_cipher_core.
module kcc_checker (
	input logic clk,
	input logic arst_n,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall
);

	// A stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result withdrawn while stalled");

	// Input back-pressure only while a result is waiting
	a_stall_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result pending");

	// Back-pressure only starts after a stalled output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(out_valid && out_stall))
		else $error("input stall without output stall");

	// Skid drains the cycle the output is taken
	a_stall_release: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall && !out_stall |=> !in_stall)
		else $error("input stall not released after output transaction");

endmodule

bind keeloq_cipher_core kcc_checker u_kcc_checker (.*);

// ===== bench/keeloq_cipher_core_tb.sv =====
// Self-checking testbench for keeloq_cipher_core: encrypt/decrypt transactions
// under several keys, checked in order against a round-by-round predictor.
// Depends on kcc_pkg and the RTL of keeloq_cipher_core only.
`timescale 1ns / 1ps

module keeloq_cipher_core_tb;
	import kcc_pkg::*;

	localparam int CIPHER_ROUNDS = 528;
	// Acceptance to out_valid, one stage per eight rounds plus the output register
	localparam int PIPE_LAT = (CIPHER_ROUNDS + ROUNDS_PER_STAGE - 1) / ROUNDS_PER_STAGE + 1;
	localparam int CYCLE_LIMIT = 600000;
	localparam int PHASE_ITEMS = 190;
	localparam int RANDOM_PHASES = 6;
	localparam int MAX_SHOWN = 10;

	// Receiver behaviour, picked afresh whenever the current mode runs out
	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_RANDOM,
		STALL_LONG,
		STALL_TOGGLE
	} stall_mode_t;

	// Holds the key in use and the blocks still due on the output, in order
	class keeloq_block_checker #(int NROUNDS = 528);
		logic [KEY_W-1:0] key;
		logic [BLK_W-1:0] due_blocks[$];
		int mismatches;
		int strays;
		int checked;
		int enc_count;
		int dec_count;

		function new();
			key = '0;
			mismatches = 0;
			strays = 0;
			checked = 0;
			enc_count = 0;
			dec_count = 0;
		endfunction

		// Full cipher pass, one shift-register round at a time
		function logic [BLK_W-1:0] keeloq_rounds(kcc_op_t op, logic [BLK_W-1:0] blk);
			logic [BLK_W-1:0] x;
			logic [4:0] tap;
			logic [KIDX_W-1:0] kidx;
			logic fb;
			x = blk;
			for (int r = 0; r < NROUNDS; r++) begin
				if (op == OP_ENCRYPT) begin
					kidx = KIDX_W'(r);
					tap = {x[31], x[26], x[20], x[9], x[1]};
					fb = x[0] ^ x[16] ^ key[kidx] ^ NLF_TABLE[tap];
					x = {fb, x[31:1]};
				end else begin
					// key index walks backwards, wrapping modulo 64
					kidx = DEC_KEY_OFS - KIDX_W'(r);
					tap = {x[30], x[25], x[19], x[8], x[0]};
					fb = x[31] ^ x[15] ^ key[kidx] ^ NLF_TABLE[tap];
					x = {x[30:0], fb};
				end
			end
			return x;
		endfunction

		// Accepted input transaction: queue the block it should produce, return it
		function logic [BLK_W-1:0] note_block(kcc_op_t op, logic [BLK_W-1:0] blk);
			logic [BLK_W-1:0] due;
			due = keeloq_rounds(op, blk);
			due_blocks.push_back(due);
			if (op == OP_ENCRYPT)
				enc_count++;
			else
				dec_count++;
			return due;
		endfunction

		// Accepted output transaction against the oldest block due
		function void check_block(logic [BLK_W-1:0] got);
			logic [BLK_W-1:0] due;
			if (due_blocks.size() == 0) begin
				strays++;
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("unexpected output transaction: block_out %08h", got);
				return;
			end
			due = due_blocks.pop_front();
			checked++;
			if (got !== due) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("mismatch on result %0d: block_out expected %08h, got %08h",
						checked, due, got);
			end
		endfunction

		function int pending();
			return due_blocks.size();
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             cipher_key_we;
	logic [KEY_W-1:0] cipher_key_wdata;
	logic             in_valid;
	logic             in_stall;
	logic             kind;
	logic [BLK_W-1:0] block_in;
	logic             out_valid;
	logic             out_stall;
	logic [BLK_W-1:0] block_out;

	keeloq_block_checker #(CIPHER_ROUNDS) blk_chk;
	int cycle_count = 0;
	int burst_left = 0;
	int keys_used = 0;
	int pauses = 0;
	stall_mode_t stall_mode = STALL_NONE;
	int stall_left = 0;
	int stall_hold = 0;

	keeloq_cipher_core #(
		.ROUNDS(CIPHER_ROUNDS)
	) dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cipher_key_we    (cipher_key_we),
		.cipher_key_wdata (cipher_key_wdata),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.kind             (kind),
		.block_in         (block_in),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.block_out        (block_out)
	);

	always #1 clk = ~clk;

	// Cycle count and run-away guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, blk_chk.pending());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Output monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			blk_chk.check_block(block_out);
	end

	// Receiver stall pattern
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (stall_left == 0) begin
				stall_mode = stall_mode_t'($urandom_range(0, 3));
				stall_left = $urandom_range(20, 200);
				stall_hold = 0;
			end
			stall_left--;
			case (stall_mode)
				STALL_NONE: begin
					out_stall <= 1'b0;
				end
				STALL_RANDOM: begin
					out_stall <= ($urandom_range(0, 99) < 35);
				end
				STALL_LONG: begin
					if (stall_hold == 0 && $urandom_range(0, 19) == 0)
						stall_hold = $urandom_range(5, 40);
					if (stall_hold > 0) begin
						stall_hold--;
						out_stall <= 1'b1;
					end else begin
						out_stall <= 1'b0;
					end
				end
				default: begin
					out_stall <= ~out_stall;
				end
			endcase
		end
	end

	// Bursts of back-to-back transactions separated by random gaps
	task automatic pace_sender();
		int gap;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 12);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 16);
		end
	endtask

	// One input transaction; returns the block the output will carry for it
	task automatic send_block(input kcc_op_t op, input logic [BLK_W-1:0] blk,
		output logic [BLK_W-1:0] due);
		@(negedge clk);
		in_valid <= 1'b1;
		kind <= op;
		block_in <= blk;
		do @(posedge clk); while (in_stall);
		due = blk_chk.note_block(op, blk);
		pace_sender();
	endtask

	// Stop sending and wait for every outstanding result
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (blk_chk.pending() != 0) @(posedge clk);
	endtask

	// Key change only with the pipeline empty
	task automatic write_key(input logic [KEY_W-1:0] k);
		drain_results();
		repeat (PIPE_LAT + 4) @(posedge clk);
		@(negedge clk);
		cipher_key_we <= 1'b1;
		cipher_key_wdata <= k;
		blk_chk.key = k;
		@(negedge clk);
		cipher_key_we <= 1'b0;
		keys_used++;
	endtask

	// Extreme blocks in both directions, plus round trips each way
	task automatic directed_set();
		logic [BLK_W-1:0] r;
		send_block(OP_ENCRYPT, '0, r);
		send_block(OP_ENCRYPT, '1, r);
		send_block(OP_DECRYPT, '0, r);
		send_block(OP_DECRYPT, '1, r);
		send_block(OP_ENCRYPT, 32'h1234_5678, r);
		send_block(OP_DECRYPT, r, r);
		send_block(OP_DECRYPT, 32'h89AB_CDEF, r);
		send_block(OP_ENCRYPT, r, r);
	endtask

	// Mostly round trips with random content, the rest single transactions
	task automatic random_phase(input logic [KEY_W-1:0] k, input int n_items);
		int sent;
		int sel;
		int bit_n;
		bit paused;
		kcc_op_t op;
		logic [BLK_W-1:0] blk;
		logic [BLK_W-1:0] due;
		logic [BLK_W-1:0] unused;
		write_key(k);
		sent = 0;
		paused = 1'b0;
		while (sent < n_items) begin
			if (!paused && sent >= n_items / 2) begin
				// let the pipeline run dry mid-phase
				drain_results();
				paused = 1'b1;
				pauses++;
			end
			op = kcc_op_t'($urandom_range(0, 1));
			bit_n = $urandom_range(0, BLK_W - 1);
			case ($urandom_range(0, 15))
				0: blk = '0;
				1: blk = '1;
				2: blk = BLK_W'(1) << bit_n;
				3: blk = ~(BLK_W'(1) << bit_n);
				default: blk = $urandom;
			endcase
			sel = $urandom_range(0, 9);
			if (sel < 6) begin
				send_block(op, blk, due);
				send_block((op == OP_ENCRYPT) ? OP_DECRYPT : OP_ENCRYPT, due, unused);
				sent += 2;
			end else begin
				send_block(op, blk, unused);
				sent++;
			end
		end
	endtask

	// Main sequence
	initial begin
		logic [KEY_W-1:0] k;
		clk = 1'b0;
		arst_n = 1'b0;
		cipher_key_we = 1'b0;
		cipher_key_wdata = '0;
		in_valid = 1'b0;
		kind = 1'b0;
		block_in = '0;
		blk_chk = new();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: reset key, all-ones key, outer key bits only
		directed_set();
		write_key('1);
		directed_set();
		write_key(64'h8000_0000_0000_0001);
		directed_set();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				1: k = '0;
				2: k = '1;
				4: k = 64'h5555_AAAA_3C3C_C3C3;
				default: k = {$urandom, $urandom};
			endcase
			random_phase(k, PHASE_ITEMS);
		end

		drain_results();
		repeat (PIPE_LAT + 8) @(posedge clk);

		$display("Covered %0d encrypt and %0d decrypt transactions over %0d key writes,",
			blk_chk.enc_count, blk_chk.dec_count, keys_used);
		$display("%0d mid-run drains; %0d results checked, %0d mismatches, %0d unexpected, %0d outstanding.",
			pauses, blk_chk.checked, blk_chk.mismatches, blk_chk.strays, blk_chk.pending());
		if (blk_chk.mismatches == 0 && blk_chk.pending() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
